// ===== hdl/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared constants, types and helper functions of the pulse-distance IR
// decoder: field widths, register codes, match windows and result codes.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // Timing base and input width
  localparam int TICK_US       = 50;
  localparam int DURATION_BITS = 16;
  localparam int DUR_IN_W      = 16;
  localparam int DUR_W         = (DURATION_BITS < DUR_IN_W) ? DURATION_BITS : DUR_IN_W;
  localparam int SCALE         = 100 * TICK_US;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TOL_W      = 6;
  localparam int EXC_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_EXCESS = 2'd2;

  localparam logic             MODE_RST = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RST  = 6'd25;
  localparam logic [EXC_W-1:0] EXC_RST  = 8'd100;

  // Nominal durations in microseconds
  localparam int NOM_HDR       = 5000;
  localparam int NOM_RPT       = 2250;
  localparam int NOM_ONE       = 1600;
  localparam int NOM_ZERO      = 560;
  localparam int NOM_SEP_LONG  = 4600;
  localparam int NOM_SEP_SHORT = 100;
  localparam int NOM_MAX       = 5000;

  // Bound arithmetic widths
  localparam int EXC_MAX     = (2 ** EXC_W) - 1;
  localparam int FAC_MAX     = 100 + (2 ** TOL_W) - 1;
  localparam int MAX_X       = (NOM_MAX + EXC_MAX) * FAC_MAX + SCALE;
  localparam int X_W         = $clog2(MAX_X + 1) + 1;
  localparam int MAG_W       = X_W - 1;
  localparam int BOUND_W     = $clog2(MAX_X / SCALE + 1);
  localparam int RECIP_SHIFT = 32;
  localparam longint RECIP   = (64'd1 << RECIP_SHIFT) / SCALE;
  localparam int PROD_W      = RECIP_SHIFT + BOUND_W + 1;
  localparam int CMP_W       = (DUR_W > BOUND_W) ? DUR_W : BOUND_W;

  // Match windows
  localparam int NUM_WIN  = 8;
  localparam int WIN_W    = $clog2(NUM_WIN);
  localparam int NUM_JOBS = 2 * NUM_WIN;
  localparam int JOB_W    = WIN_W + 1;

  localparam logic [WIN_W-1:0] WIN_HDR_MARK  = WIN_W'(0);
  localparam logic [WIN_W-1:0] WIN_BIT_MARK  = WIN_W'(1);
  localparam logic [WIN_W-1:0] WIN_HDR_SPACE = WIN_W'(2);
  localparam logic [WIN_W-1:0] WIN_RPT_SPACE = WIN_W'(3);
  localparam logic [WIN_W-1:0] WIN_ONE_SPACE = WIN_W'(4);
  localparam logic [WIN_W-1:0] WIN_ZRO_SPACE = WIN_W'(5);
  localparam logic [WIN_W-1:0] WIN_SEP_LONG  = WIN_W'(6);
  localparam logic [WIN_W-1:0] WIN_SEP_SHORT = WIN_W'(7);

  // Capture state
  localparam int IDX_W   = 7;
  localparam int BITS_W  = 6;
  localparam int MAIN_W  = 32;
  localparam int EXTRA_W = 4;
  localparam logic [IDX_W-1:0]  IDX_MAX   = 7'd127;
  localparam logic [BITS_W-1:0] TARGET_32 = 6'd32;
  localparam logic [BITS_W-1:0] TARGET_36 = 6'd36;

  // Result codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_DECODED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPEAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

  // One tick window: lo..hi inclusive, empty when no tick count can match
  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic               empty;
  } win_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BITS_W-1:0]   bit_count;
    logic [MAIN_W-1:0]   value_main;
    logic [EXTRA_W-1:0]  value_extra;
  } res_t;

  function automatic int win_nominal(input logic [WIN_W-1:0] w);
    int us;
    case (w)
      WIN_HDR_MARK:  us = NOM_HDR;
      WIN_BIT_MARK:  us = NOM_ZERO;
      WIN_HDR_SPACE: us = NOM_HDR;
      WIN_RPT_SPACE: us = NOM_RPT;
      WIN_ONE_SPACE: us = NOM_ONE;
      WIN_ZRO_SPACE: us = NOM_ZERO;
      WIN_SEP_LONG:  us = NOM_SEP_LONG;
      default:       us = NOM_SEP_SHORT;
    endcase
    return us;
  endfunction

  function automatic logic win_is_mark(input logic [WIN_W-1:0] w);
    return (w == WIN_HDR_MARK) || (w == WIN_BIT_MARK);
  endfunction

endpackage

// ===== hdl/ipd_ifs.sv =====
// ----------------------------------------------------------------------------
// ipd_ifs
// Valid/ready channels of the IR decoder: capture entries in, status out.
// ----------------------------------------------------------------------------
interface ipd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ipd_pkg::DUR_IN_W-1:0]  duration_ticks;
  logic                          frame_start;
  logic                          frame_end;

  modport source (output valid, duration_ticks, frame_start, frame_end, input ready);
  modport sink   (input valid, duration_ticks, frame_start, frame_end, output ready);
endinterface

interface ipd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ipd_pkg::STATUS_W-1:0]  status;
  logic [ipd_pkg::BITS_W-1:0]    bit_count;
  logic [ipd_pkg::MAIN_W-1:0]    value_main;
  logic [ipd_pkg::EXTRA_W-1:0]   value_extra;

  modport source (output valid, status, bit_count, value_main, value_extra, input ready);
  modport sink   (input valid, status, bit_count, value_main, value_extra, output ready);
endinterface

// ===== hdl/ipd_cfg_bounds.sv =====
// ----------------------------------------------------------------------------
// ipd_cfg_bounds
// Configuration registers and the tick window table. After reset and after
// every register write, a three-step pipeline recomputes the lo/hi tick
// bounds of all windows, one bound per cycle, and holds busy meanwhile.
// ----------------------------------------------------------------------------
module ipd_cfg_bounds (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              frame_mode,
  output ipd_pkg::win_t [ipd_pkg::NUM_WIN-1:0] bounds,
  output logic                              busy
);

  localparam int X_W   = ipd_pkg::X_W;
  localparam int MAG_W = ipd_pkg::MAG_W;
  localparam int BW    = ipd_pkg::BOUND_W;
  localparam int WW    = ipd_pkg::WIN_W;
  localparam int JW    = ipd_pkg::JOB_W;

  logic                       mode_r;
  logic [ipd_pkg::TOL_W-1:0]  tol_r;
  logic [ipd_pkg::EXC_W-1:0]  exc_r;
  logic [JW:0]                cnt_r;
  logic                       issue;
  logic [WW-1:0]              job_win;
  logic                       job_hi;

  logic signed [X_W-1:0]      us_x;
  logic signed [X_W-1:0]      fac_x;
  logic signed [X_W-1:0]      x_nxt;
  logic                       s0_vld_r;
  logic [WW-1:0]              s0_win_r;
  logic                       s0_hi_r;
  logic signed [X_W-1:0]      s0_x_r;

  logic [MAG_W-1:0]           mag_nxt;
  logic [ipd_pkg::PROD_W-1:0] prod;
  logic                       s1_vld_r;
  logic [WW-1:0]              s1_win_r;
  logic                       s1_hi_r;
  logic                       s1_neg_r;
  logic [MAG_W-1:0]           s1_mag_r;
  logic [BW-1:0]              s1_q0_r;

  logic [MAG_W:0]             rem;
  logic [BW-1:0]              q_fin;
  ipd_pkg::win_t              bnd_r [ipd_pkg::NUM_WIN];

  // Select the next bound job: window in the upper bits, lo/hi in bit 0
  assign issue   = (cnt_r != (JW+1)'(ipd_pkg::NUM_JOBS));
  assign job_win = cnt_r[JW-1:1];
  assign job_hi  = cnt_r[0];
  assign busy    = issue || s0_vld_r || s1_vld_r;

  // Step 0: signed microsecond target times percent factor, plus scale for hi
  always_comb begin
    if (ipd_pkg::win_is_mark(job_win)) begin
      us_x = X_W'(ipd_pkg::win_nominal(job_win)) + X_W'(exc_r);
    end else begin
      us_x = X_W'(ipd_pkg::win_nominal(job_win)) - X_W'(exc_r);
    end
    if (job_hi) begin
      fac_x = X_W'(100) + X_W'(tol_r);
      x_nxt = us_x * fac_x + X_W'(ipd_pkg::SCALE);
    end else begin
      fac_x = X_W'(100) - X_W'(tol_r);
      x_nxt = us_x * fac_x;
    end
  end

  // Step 1: magnitude and reciprocal estimate of magnitude / scale
  assign mag_nxt = s0_x_r[X_W-1] ? MAG_W'(-s0_x_r) : MAG_W'(s0_x_r);
  assign prod    = ipd_pkg::PROD_W'(mag_nxt) * ipd_pkg::PROD_W'(ipd_pkg::RECIP);

  // Step 2: correct the estimate by one where the remainder is too large
  assign rem   = (MAG_W+1)'(s1_mag_r) - (MAG_W+1)'(s1_q0_r) * (MAG_W+1)'(ipd_pkg::SCALE);
  assign q_fin = (rem >= (MAG_W+1)'(ipd_pkg::SCALE)) ? s1_q0_r + BW'(1) : s1_q0_r;

  // Control: config registers, job counter, stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ipd_pkg::MODE_RST;
      tol_r    <= ipd_pkg::TOL_RST;
      exc_r    <= ipd_pkg::EXC_RST;
      cnt_r    <= '0;
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ipd_pkg::CFG_FRAME_MODE:  mode_r <= cfg_wdata[0];
          ipd_pkg::CFG_TOLERANCE:   tol_r  <= cfg_wdata[ipd_pkg::TOL_W-1:0];
          ipd_pkg::CFG_MARK_EXCESS: exc_r  <= cfg_wdata[ipd_pkg::EXC_W-1:0];
          default: ;
        endcase
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + (JW+1)'(1);
      end
      s0_vld_r <= issue && !cfg_we;
      s1_vld_r <= s0_vld_r && !cfg_we;
    end
  end

  // Datapath: stage payloads and window table writes
  always_ff @(posedge clk) begin
    s0_win_r <= job_win;
    s0_hi_r  <= job_hi;
    s0_x_r   <= x_nxt;
    s1_win_r <= s0_win_r;
    s1_hi_r  <= s0_hi_r;
    s1_neg_r <= s0_x_r[X_W-1];
    s1_mag_r <= mag_nxt;
    s1_q0_r  <= prod[ipd_pkg::RECIP_SHIFT +: BW];
    if (s1_vld_r) begin
      if (s1_hi_r) begin
        bnd_r[s1_win_r].hi    <= s1_neg_r ? '0 : q_fin;
        bnd_r[s1_win_r].empty <= s1_neg_r && (q_fin != '0);
      end else begin
        bnd_r[s1_win_r].lo    <= s1_neg_r ? '0 : q_fin;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < ipd_pkg::NUM_WIN; w++) begin
      bounds[w] = bnd_r[w];
    end
  end

  assign frame_mode = mode_r;

  // A register write always restarts the table pass
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("table pass not restarted after register write");

endmodule

// ===== hdl/ipd_frame_decode.sv =====
// ----------------------------------------------------------------------------
// ipd_frame_decode
// Input register, capture state update and result register. Each entry is
// matched against the window table and folded into the capture state in
// one step; the entry that ends a capture loads the status register.
// ----------------------------------------------------------------------------
module ipd_frame_decode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 frame_mode,
  input  ipd_pkg::win_t [ipd_pkg::NUM_WIN-1:0] bounds,
  input  logic                                 busy,
  ipd_in_if.sink                               in_ch,
  ipd_out_if.source                            out_ch
);

  localparam int IW = ipd_pkg::IDX_W;
  localparam int BT = ipd_pkg::BITS_W;
  localparam int CW = ipd_pkg::CMP_W;

  // Input register
  logic                      in_vld_r;
  logic [ipd_pkg::DUR_W-1:0] dur_r;
  logic                      start_r;
  logic                      end_r;
  logic                      adv;
  logic                      in_rdy;

  // Capture state
  logic [IW-1:0]               eidx_r, eidx_nxt;
  logic [BT-1:0]               bits_r, bits_nxt;
  logic [ipd_pkg::MAIN_W-1:0]  main_r, main_nxt;
  logic [ipd_pkg::EXTRA_W-1:0] extra_r, extra_nxt;
  logic                        mis_r, mis_nxt;
  logic                        hdr_r, hdr_nxt;
  logic                        rpt_r, rpt_nxt;

  // Working values
  logic [CW-1:0]               dur_c;
  logic [ipd_pkg::NUM_WIN-1:0] hit;
  logic [BT-1:0]               target;
  logic [IW-1:0]               idx;
  logic                        push;
  logic                        push_val;

  // Result register
  logic          out_vld_r, out_vld_nxt;
  ipd_pkg::res_t res_r, res_nxt;

  // Advance the held entry unless it would overwrite an untaken result
  assign adv    = in_vld_r && (!end_r || !out_vld_r || out_ch.ready);
  assign in_rdy = !busy && (!in_vld_r || adv);
  assign in_ch.ready = in_rdy;

  // Window hits on the held duration
  assign dur_c = CW'(dur_r);
  always_comb begin
    for (int w = 0; w < ipd_pkg::NUM_WIN; w++) begin
      hit[w] = (dur_c >= CW'(bounds[w].lo)) && (dur_c <= CW'(bounds[w].hi)) &&
               !bounds[w].empty;
    end
  end

  assign target = frame_mode ? ipd_pkg::TARGET_36 : ipd_pkg::TARGET_32;

  // Fold one entry into the capture state and build the result
  always_comb begin
    eidx_nxt    = eidx_r;
    bits_nxt    = bits_r;
    main_nxt    = main_r;
    extra_nxt   = extra_r;
    mis_nxt     = mis_r;
    hdr_nxt     = hdr_r;
    rpt_nxt     = rpt_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    res_nxt     = res_r;
    push        = 1'b0;
    push_val    = 1'b0;
    idx         = eidx_r;

    if (adv) begin
      // drop the old capture on a start entry
      if (start_r) begin
        eidx_nxt  = '0;
        bits_nxt  = '0;
        main_nxt  = '0;
        extra_nxt = '0;
        mis_nxt   = 1'b0;
        hdr_nxt   = 1'b0;
        rpt_nxt   = 1'b0;
      end
      idx = eidx_nxt;
      if (eidx_nxt != ipd_pkg::IDX_MAX) begin
        eidx_nxt = eidx_nxt + IW'(1);
      end

      if (idx == IW'(1)) begin
        if (!hit[ipd_pkg::WIN_HDR_MARK]) begin
          mis_nxt = 1'b1;
        end
      end else if (idx == IW'(2)) begin
        hdr_nxt = hit[ipd_pkg::WIN_HDR_SPACE];
        rpt_nxt = hit[ipd_pkg::WIN_RPT_SPACE];
      end else if (idx >= IW'(3)) begin
        if (idx == IW'(3)) begin
          rpt_nxt = rpt_nxt && hit[ipd_pkg::WIN_BIT_MARK];
        end
        if (!mis_nxt && (bits_nxt < target)) begin
          if (idx == ipd_pkg::IDX_MAX) begin
            mis_nxt = 1'b1;
          end else if (idx[0]) begin
            if (!hit[ipd_pkg::WIN_BIT_MARK]) begin
              mis_nxt = 1'b1;
            end
          end else if (hit[ipd_pkg::WIN_ONE_SPACE]) begin
            push     = 1'b1;
            push_val = 1'b1;
          end else if (hit[ipd_pkg::WIN_ZRO_SPACE]) begin
            push     = 1'b1;
          end else if (frame_mode && (hit[ipd_pkg::WIN_SEP_LONG] ||
                                      hit[ipd_pkg::WIN_SEP_SHORT])) begin
            // separator space: no bit
          end else begin
            mis_nxt = 1'b1;
          end
        end
      end

      // shift the bit into the main word, then into the extra nibble
      if (push) begin
        if (bits_nxt < ipd_pkg::TARGET_32) begin
          main_nxt = {main_nxt[ipd_pkg::MAIN_W-2:0], push_val};
        end else begin
          extra_nxt = {extra_nxt[ipd_pkg::EXTRA_W-2:0], push_val};
        end
        bits_nxt = bits_nxt + BT'(1);
      end

      // on the last entry, load the result and clear the capture
      if (end_r) begin
        out_vld_nxt         = 1'b1;
        res_nxt.status      = ipd_pkg::ST_NO_MATCH;
        res_nxt.bit_count   = '0;
        res_nxt.value_main  = '0;
        res_nxt.value_extra = '0;
        if (!frame_mode && (eidx_nxt == IW'(4)) && !mis_nxt && rpt_nxt) begin
          res_nxt.status     = ipd_pkg::ST_REPEAT;
          res_nxt.value_main = '1;
        end else if ((eidx_nxt >= IW'({target, 1'b0}) + IW'(4)) && !mis_nxt &&
                     hdr_nxt && (bits_nxt == target)) begin
          res_nxt.status      = ipd_pkg::ST_DECODED;
          res_nxt.bit_count   = target;
          res_nxt.value_main  = main_nxt;
          res_nxt.value_extra = frame_mode ? extra_nxt : '0;
        end
        eidx_nxt  = '0;
        bits_nxt  = '0;
        main_nxt  = '0;
        extra_nxt = '0;
        mis_nxt   = 1'b0;
        hdr_nxt   = 1'b0;
        rpt_nxt   = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      eidx_r    <= '0;
      bits_r    <= '0;
      main_r    <= '0;
      extra_r   <= '0;
      mis_r     <= 1'b0;
      hdr_r     <= 1'b0;
      rpt_r     <= 1'b0;
    end else begin
      if (in_ch.valid && in_rdy) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      out_vld_r <= out_vld_nxt;
      eidx_r    <= eidx_nxt;
      bits_r    <= bits_nxt;
      main_r    <= main_nxt;
      extra_r   <= extra_nxt;
      mis_r     <= mis_nxt;
      hdr_r     <= hdr_nxt;
      rpt_r     <= rpt_nxt;
    end
  end

  // Payload registers: hold the request until it advances
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_rdy) begin
      dur_r   <= in_ch.duration_ticks[ipd_pkg::DUR_W-1:0];
      start_r <= in_ch.frame_start;
      end_r   <= in_ch.frame_end;
    end
    res_r <= res_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.bit_count   = res_r.bit_count;
  assign out_ch.value_main  = res_r.value_main;
  assign out_ch.value_extra = res_r.value_extra;

  a_decoded_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.status == ipd_pkg::ST_DECODED) |->
      (res_r.bit_count == ipd_pkg::TARGET_32) || (res_r.bit_count == ipd_pkg::TARGET_36))
    else $error("decoded frame with odd bit count");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.status != ipd_pkg::ST_DECODED) |->
      (res_r.bit_count == '0) && (res_r.value_extra == '0))
    else $error("non-decoded result carries bits");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && end_r |=> out_vld_r)
    else $error("end entry did not load a result");

  a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= ipd_pkg::TARGET_36)
    else $error("bit counter ran past frame length");

endmodule

// ===== hdl/ir_pulse_distance_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// Pulse-distance IR remote decoder for 32-bit frames with repeat code and
// 36-bit frames with separators; one captured duration per request.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------
//  in_ch    | in  | valid/ready      | duration_ticks, frame_start, frame_end
//  out_ch   | out | valid/ready      | status, bit_count, value_main, value_extra
//  cfg_*    | in  | cfg_we           | cfg_index, cfg_wdata (write only)
//
//  One request per cycle while the table is not rebuilt and no result stalls;
//  a result passes the input register, then the result register.
//  After reset and after every config write, the window table is rebuilt
//  one bound per cycle through a three-step divide pipeline; ready stays
//  low meanwhile.
//  A stalled result register holds only the entry that ends a capture; other
//  entries keep flowing.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  ipd_in_if.sink                         in_ch,
  ipd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                                 frame_mode;
  logic                                 busy;
  ipd_pkg::win_t [ipd_pkg::NUM_WIN-1:0] bounds;

  // Config registers and window table
  ipd_cfg_bounds u_bounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .frame_mode (frame_mode),
    .bounds     (bounds),
    .busy       (busy)
  );

  // Per-entry decode
  ipd_frame_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_mode (frame_mode),
    .bounds     (bounds),
    .busy       (busy),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse-distance IR decoder. Captures (header,
// mark/space bit pairs, separators, repeat codes, noise) go in over the
// valid/ready input channel. A request-level decoder model in this bench turns
// every accepted request into the status it should cause, and each status
// that leaves the block is checked field by field against the oldest one.
// Several register settings are run, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 1950;
  localparam int NUM_PHASES     = 8;

  typedef struct {
    logic [ipd_pkg::DUR_IN_W-1:0] duration_ticks;
    logic                         frame_start;
    logic                         frame_end;
    bit                           wait_drain;
  } entry_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ipd_in_if  in_ch ();
  ipd_out_if out_ch ();

  ir_pulse_distance_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Pending requests, statuses still owed by the block, scratch capture
  entry_t        entry_queue[$];
  ipd_pkg::res_t status_due[$];
  entry_t        frame_buf[$];

  // Register copies
  bit cfg_mode;
  int cfg_tol;
  int cfg_excess;

  // Decoder model state
  int          cap_index;
  int          cap_bits;
  logic [31:0] cap_main;
  logic [3:0]  cap_extra;
  bit          cap_bad;
  bit          hdr_ok;
  bit          rpt_ok;

  int fail_count;
  int items_queued;
  bit calm;
  bit in_taken;
  int in_gap;
  int out_stall;
  int idle_cycles;
  entry_t on_bus;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------- model

  function automatic void window_bounds(input int us, output longint lo, output longint hi);
    lo = (longint'(us) * (100 - cfg_tol)) / ipd_pkg::SCALE;
    hi = (longint'(us) * (100 + cfg_tol) + ipd_pkg::SCALE) / ipd_pkg::SCALE;
  endfunction

  function automatic bit fits_window(input int ticks, input int us);
    longint lo, hi;
    window_bounds(us, lo, hi);
    return (ticks >= lo) && (ticks <= hi);
  endfunction

  function automatic bit fits_mark(input int ticks, input int us);
    return fits_window(ticks, us + cfg_excess);
  endfunction

  function automatic bit fits_space(input int ticks, input int us);
    return fits_window(ticks, us - cfg_excess);
  endfunction

  function automatic void clear_capture();
    cap_index = 0;
    cap_bits  = 0;
    cap_main  = '0;
    cap_extra = '0;
    cap_bad   = 1'b0;
    hdr_ok    = 1'b0;
    rpt_ok    = 1'b0;
  endfunction

  function automatic void shift_in(input bit b);
    if (cap_bits < 32) cap_main = {cap_main[30:0], b};
    else cap_extra = {cap_extra[2:0], b};
    cap_bits++;
  endfunction

  // Advance the decoder by one request; queue the status that it ends with
  function automatic void decode_entry(input int d, input bit fs, input bit fe);
    bit            wide;
    int            target;
    int            idx;
    ipd_pkg::res_t res;
    wide   = cfg_mode;
    target = wide ? 36 : 32;
    if (fs) clear_capture();
    idx = cap_index;
    if (cap_index < 127) cap_index++;

    if (idx == 1) begin
      if (!fits_mark(d, ipd_pkg::NOM_HDR)) cap_bad = 1'b1;
    end else if (idx == 2) begin
      hdr_ok = fits_space(d, ipd_pkg::NOM_HDR);
      rpt_ok = fits_space(d, ipd_pkg::NOM_RPT);
    end else if (idx >= 3) begin
      if (idx == 3) rpt_ok = rpt_ok && fits_mark(d, ipd_pkg::NOM_ZERO);
      if (!cap_bad && cap_bits < target) begin
        if (idx >= 127) begin
          cap_bad = 1'b1;
        end else if (idx % 2 == 1) begin
          if (!fits_mark(d, ipd_pkg::NOM_ZERO)) cap_bad = 1'b1;
        end else if (fits_space(d, ipd_pkg::NOM_ONE)) begin
          shift_in(1'b1);
        end else if (fits_space(d, ipd_pkg::NOM_ZERO)) begin
          shift_in(1'b0);
        end else if (wide && (fits_space(d, ipd_pkg::NOM_SEP_LONG) ||
                              fits_space(d, ipd_pkg::NOM_SEP_SHORT))) begin
          // separator: skip, no bit
        end else begin
          cap_bad = 1'b1;
        end
      end
    end

    if (!fe) return;
    res.status      = ipd_pkg::ST_NO_MATCH;
    res.bit_count   = '0;
    res.value_main  = '0;
    res.value_extra = '0;
    if (!wide && cap_index == 4 && !cap_bad && rpt_ok) begin
      res.status     = ipd_pkg::ST_REPEAT;
      res.value_main = '1;
    end else if (cap_index >= 2 * target + 4 && !cap_bad && hdr_ok && cap_bits == target) begin
      res.status      = ipd_pkg::ST_DECODED;
      res.bit_count   = ipd_pkg::BITS_W'(target);
      res.value_main  = cap_main;
      res.value_extra = wide ? cap_extra : 4'h0;
    end
    status_due.push_back(res);
    clear_capture();
  endfunction

  // ------------------------------------------------------------- stimulus

  // Tick count inside the window of a nominal duration, edges favored
  function automatic int pick_ticks(input int us, input bit is_mark);
    longint lo, hi;
    int     r;
    window_bounds(is_mark ? us + cfg_excess : us - cfg_excess, lo, hi);
    if (hi < 0) return $urandom_range(0, 3);
    if (lo < 0) lo = 0;
    r = $urandom_range(0, 7);
    if (r == 0) return int'(lo);
    if (r == 1) return int'(hi);
    return $urandom_range(int'(hi), int'(lo));
  endfunction

  function automatic int noise_ticks();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 200);
  endfunction

  function automatic void add_entry(input int dur, input bit fs);
    entry_t e;
    e.duration_ticks = ipd_pkg::DUR_IN_W'(dur);
    e.frame_start    = fs;
    e.frame_end      = 1'b0;
    e.wait_drain     = 1'b0;
    frame_buf.push_back(e);
  endfunction

  // Close the scratch capture with frame_end and hand it to the driver
  function automatic void commit_frame(input bit corrupt, input bit hold);
    int k;
    if (corrupt && frame_buf.size() > 1) begin
      k = $urandom_range(1, frame_buf.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        frame_buf[k].duration_ticks = ipd_pkg::DUR_IN_W'(noise_ticks());
      end else begin
        frame_buf[k].duration_ticks = frame_buf[k].duration_ticks +
                                      ipd_pkg::DUR_IN_W'($urandom_range(1, 3));
      end
    end
    frame_buf[0].wait_drain = hold;
    frame_buf[frame_buf.size() - 1].frame_end = 1'b1;
    foreach (frame_buf[i]) entry_queue.push_back(frame_buf[i]);
    items_queued += frame_buf.size();
    frame_buf.delete();
  endfunction

  // Header, bit pairs with separators mixed in, stop mark, trailing entries
  function automatic void queue_frame(input int n_bits, input int n_sep, input int n_extra,
                                      input logic [35:0] pattern, input bit corrupt,
                                      input bit hold);
    int bits_left;
    int sep_left;
    int b;
    bits_left = n_bits;
    sep_left  = n_sep;
    b         = 0;
    add_entry($urandom_range(0, 65535), $urandom_range(0, 4) != 0);
    add_entry(pick_ticks(ipd_pkg::NOM_HDR, 1'b1), 1'b0);
    add_entry(pick_ticks(ipd_pkg::NOM_HDR, 1'b0), 1'b0);
    while (bits_left + sep_left > 0) begin
      add_entry(pick_ticks(ipd_pkg::NOM_ZERO, 1'b1), 1'b0);
      if (sep_left > 0 && $urandom_range(0, bits_left + sep_left - 1) < sep_left) begin
        add_entry(pick_ticks($urandom_range(0, 1) ? ipd_pkg::NOM_SEP_LONG :
                                                    ipd_pkg::NOM_SEP_SHORT, 1'b0), 1'b0);
        sep_left--;
      end else begin
        add_entry(pick_ticks(pattern[35 - (b % 36)] ? ipd_pkg::NOM_ONE :
                                                      ipd_pkg::NOM_ZERO, 1'b0), 1'b0);
        b++;
        bits_left--;
      end
    end
    add_entry(pick_ticks(ipd_pkg::NOM_ZERO, 1'b1), 1'b0);
    repeat (n_extra) add_entry(noise_ticks(), 1'b0);
    commit_frame(corrupt, hold);
  endfunction

  function automatic void queue_repeat(input bit corrupt);
    add_entry($urandom_range(0, 65535), 1'b1);
    add_entry(pick_ticks(ipd_pkg::NOM_HDR, 1'b1), 1'b0);
    add_entry(pick_ticks(ipd_pkg::NOM_RPT, 1'b0), 1'b0);
    add_entry(pick_ticks(ipd_pkg::NOM_ZERO, 1'b1), 1'b0);
    commit_frame(corrupt, 1'b0);
  endfunction

  // Random durations with stray start and end flags
  function automatic void queue_noise(input int len);
    repeat (len) begin
      add_entry(noise_ticks(), $urandom_range(0, 7) == 0);
      frame_buf[frame_buf.size() - 1].frame_end = ($urandom_range(0, 9) == 0);
    end
    commit_frame(1'b0, 1'b0);
  endfunction

  function automatic logic [35:0] random_bits();
    return 36'({$urandom(), $urandom()});
  endfunction

  // Share the requests still to send evenly over the phases left
  function automatic int phase_budget(input int p);
    return (ITEM_TARGET - items_queued) / (NUM_PHASES - p);
  endfunction

  function automatic void random_mix(input int budget);
    int first;
    int target;
    int r;
    first = items_queued;
    while (items_queued - first < budget) begin
      target = cfg_mode ? 36 : 32;
      r = $urandom_range(0, 19);
      if (r <= 10) begin
        queue_frame(target, cfg_mode ? $urandom_range(0, 4) : int'(r == 10),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0,
                    random_bits(), $urandom_range(0, 3) == 0, $urandom_range(0, 11) == 0);
      end else if (r <= 13) begin
        queue_repeat($urandom_range(0, 3) == 0);
      end else if (r <= 16) begin
        queue_noise($urandom_range(1, 12));
      end else if (r == 17) begin
        queue_frame($urandom_range(0, target - 1), 0, 0, random_bits(), 1'b0, 1'b0);
      end else if (r == 18) begin
        queue_frame(target + $urandom_range(1, 3), 0, 0, random_bits(), 1'b0, 1'b0);
      end else if (cfg_mode) begin
        queue_frame(target, $urandom_range(20, 40), 0, random_bits(), 1'b0, 1'b0);
      end else begin
        queue_frame(target, 0, $urandom_range(40, 70), random_bits(), 1'b0, 1'b0);
      end
    end
  endfunction

  // ---------------------------------------------------------- phase control

  task automatic write_reg(input logic [ipd_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= ipd_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ipd_pkg::CFG_FRAME_MODE:  cfg_mode   = val[0];
      ipd_pkg::CFG_TOLERANCE:   cfg_tol    = val;
      ipd_pkg::CFG_MARK_EXCESS: cfg_excess = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input bit mode, input int tol, input int exc);
    write_reg(ipd_pkg::CFG_FRAME_MODE, int'(mode));
    write_reg(ipd_pkg::CFG_TOLERANCE, tol);
    write_reg(ipd_pkg::CFG_MARK_EXCESS, exc);
  endtask

  // Hold until every request is taken and every status is back, then settle
  task automatic drain();
    while (entry_queue.size() != 0 || in_ch.valid || status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.duration_ticks = '0;
    in_ch.frame_start    = 1'b0;
    in_ch.frame_end      = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_mode             = ipd_pkg::MODE_RST;
    cfg_tol              = int'(ipd_pkg::TOL_RST);
    cfg_excess           = int'(ipd_pkg::EXC_RST);
    clear_capture();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, 32-bit mode: directed captures
    add_entry(0, 1'b1);
    commit_frame(1'b0, 1'b0);
    add_entry(65535, 1'b1);
    commit_frame(1'b0, 1'b0);
    queue_frame(32, 0, 0, 36'h0, 1'b0, 1'b0);
    queue_frame(32, 0, 0, '1, 1'b0, 1'b1);
    queue_repeat(1'b0);
    queue_frame(20, 0, 0, random_bits(), 1'b0, 1'b0);
    queue_frame(32, 1, 0, random_bits(), 1'b0, 1'b0);
    queue_frame(32, 0, 60, random_bits(), 1'b0, 1'b0);
    queue_noise(3);
    random_mix(phase_budget(0));
    drain();

    // 36-bit mode: directed captures
    set_config(1'b1, 25, 100);
    queue_frame(36, 3, 0, random_bits(), 1'b0, 1'b0);
    queue_frame(36, 0, 0, '1, 1'b0, 1'b0);
    queue_frame(36, 30, 0, random_bits(), 1'b0, 1'b0);
    queue_repeat(1'b0);
    queue_frame(32, 0, 0, random_bits(), 1'b0, 1'b0);
    random_mix(phase_budget(1));
    drain();

    for (int p = 2; p < NUM_PHASES; p++) begin
      case (p)
        2: set_config(1'b0, 0, 0);
        3: set_config(1'b1, 50, 255);
        4: set_config(1'b0, 50, 255);
        5: set_config(1'b1, 0, 0);
        default: set_config(1'($urandom_range(0, 1)), $urandom_range(0, 50),
                            $urandom_range(0, 255));
      endcase
      if (p == NUM_PHASES - 1) calm = 1'b1;
      random_mix(phase_budget(p));
      drain();
    end

    repeat (8) @(posedge clk);
    if (status_due.size() != 0)
      flag_mismatch($sformatf("%0d statuses never arrived", status_due.size()));
    if (fail_count == 0) begin
      $display("ir_pulse_distance_decoder verification clean");
    end else begin
      $display("ir_pulse_distance_decoder verification failed");
    end
    $finish;
  end

  // ------------------------------------------------------------ channels

  // Request driver: advance after each accepted request, idle in bursts
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (entry_queue.size() != 0 &&
                   !(entry_queue[0].wait_drain && status_due.size() != 0)) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 16) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          on_bus = entry_queue.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.duration_ticks <= on_bus.duration_ticks;
          in_ch.frame_start    <= on_bus.frame_start;
          in_ch.frame_end      <= on_bus.frame_end;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: stall in bursts
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(1, 16) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check statuses, predict from accepted requests, watch for a hang
  always @(posedge clk) begin
    ipd_pkg::res_t got;
    ipd_pkg::res_t want;
    bit            moved;
    moved = 1'b0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved           = 1'b1;
      got.status      = out_ch.status;
      got.bit_count   = out_ch.bit_count;
      got.value_main  = out_ch.value_main;
      got.value_extra = out_ch.value_extra;
      if (status_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected status %0d value %h", got.status, got.value_main));
      end else begin
        want = status_due.pop_front();
        if (got.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.bit_count !== want.bit_count)
          flag_mismatch($sformatf("bit_count %0d, want %0d", got.bit_count, want.bit_count));
        if (got.value_main !== want.value_main)
          flag_mismatch($sformatf("value_main %h, want %h", got.value_main, want.value_main));
        if (got.value_extra !== want.value_extra)
          flag_mismatch($sformatf("value_extra %h, want %h", got.value_extra,
                                  want.value_extra));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      moved    = 1'b1;
      in_taken = 1'b1;
      decode_entry(int'(in_ch.duration_ticks), in_ch.frame_start, in_ch.frame_end);
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no request or status moved for %0d cycles", WATCHDOG_LIMIT);
      $display("ir_pulse_distance_decoder verification failed");
      $finish;
    end
  end

endmodule
